>>> hw/rtl/tac_pkg.sv
// Shared types, widths and the arctangent table of the twist-to-Ackermann command block.
`timescale 1ns / 1ps
`default_nettype none
package tac_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int ATAN_IDX_W    = 5;
   localparam int PRESHIFT      = 24;

   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int SPEED_W       = 16;
   localparam int YAW_W         = 16;
   localparam int WB_W          = 16;
   localparam int SLIM_W        = 15;
   localparam int STLIM_W       = 11;
   localparam int STEER_W       = 12;

   localparam int Y_W           = 33;   // wheelbase * yaw rate
   localparam int XMAG_W        = 25;   // |speed| * 1000
   localparam int XY_W          = 58;   // cordic x/y datapath
   localparam int Z_W           = 34;   // angle, radians * 2^30
   localparam int MAG_W         = Z_W - 1;
   localparam int SCALE_W       = 10;
   localparam int PROD_W        = MAG_W + SCALE_W;
   localparam int FRAC_W        = 30;
   localparam int R_W           = PROD_W - FRAC_W;

   localparam logic [SCALE_W-1:0]      MRAD_SCALE = 10'd1000;
   localparam logic signed [Z_W-1:0]   PI_Q30     = 34'sd3373259426;
   localparam logic [PROD_W-1:0]       ROUND_HALF = PROD_W'(64'd1 << (FRAC_W - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WHEELBASE   = 2'd0,
      CSR_SPEED_LIMIT = 2'd1,
      CSR_STEER_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] linear_speed;
      logic signed [YAW_W-1:0]   yaw_rate;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_cmd;
      logic signed [STEER_W-1:0] steering_cmd;
   } rsp_type;

   // Token passed from cell to cell: vector, angle and the sideband of one command.
   typedef struct packed {
      logic                      valid;
      logic                      zero;
      logic signed [SPEED_W-1:0] speed;
      logic signed [XY_W-1:0]    x;
      logic signed [XY_W-1:0]    y;
      logic signed [Z_W-1:0]     z;
   } cell_type;

   // atan(2^-i) * 2^30, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         5'd0:    a = 34'sd843314857;
         5'd1:    a = 34'sd497837829;
         5'd2:    a = 34'sd263043837;
         5'd3:    a = 34'sd133525159;
         5'd4:    a = 34'sd67021687;
         5'd5:    a = 34'sd33543516;
         5'd6:    a = 34'sd16775851;
         5'd7:    a = 34'sd8388437;
         5'd8:    a = 34'sd4194283;
         5'd9:    a = 34'sd2097149;
         5'd10:   a = 34'sd1048576;
         5'd11:   a = 34'sd524288;
         5'd12:   a = 34'sd262144;
         5'd13:   a = 34'sd131072;
         5'd14:   a = 34'sd65536;
         5'd15:   a = 34'sd32768;
         5'd16:   a = 34'sd16384;
         5'd17:   a = 34'sd8192;
         5'd18:   a = 34'sd4096;
         5'd19:   a = 34'sd2048;
         5'd20:   a = 34'sd1024;
         5'd21:   a = 34'sd512;
         5'd22:   a = 34'sd256;
         5'd23:   a = 34'sd128;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/twist_to_ackermann_command.sv
// Twist to Ackermann command: clamped speed and atan2 steering angle in mrad.
// Pipeline: two front stages, one per cordic cell, two back, the first loaded at the
// transfer edge; the result ports are driven from the last back stage registers.
// Throughput: one command per cycle; busy never rises, no stall.
// Reset (synchronous, active high) empties the pipeline and loads the default limits.
`timescale 1ns / 1ps
`default_nettype none
module twist_to_ackermann_command (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // command channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire tac_pkg::req_type                 req_data,
   // result channel
   output logic                                  rsp_strobe,
   output tac_pkg::rsp_type                      rsp_data,
   // register writes
   input  wire logic                             csr_we,
   input  wire logic [tac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tac_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tac_pkg::*;

   localparam logic [WB_W-1:0]    WHEELBASE_RST   = 16'd1000;
   localparam logic [SLIM_W-1:0]  SPEED_LIMIT_RST = 15'd2222;
   localparam logic [STLIM_W-1:0] STEER_LIMIT_RST = 11'd340;

   logic [WB_W-1:0]    wheelbase_ff, wheelbase_in;
   logic [SLIM_W-1:0]  speed_limit_ff, speed_limit_in;
   logic [STLIM_W-1:0] steer_limit_ff, steer_limit_in;

   logic               accept;

   // cell_q[0] is the front end output, cell_q[i+1] the output of cordic cell i
   cell_type           cell_q [CORDIC_STAGES+1];

   // The datapath is a pure pipeline: no stall, so always ready.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Register file. Writes must land only while the pipeline is drained; the block does not
   // enforce this, and the stages read the limits directly without shadow copies.
   always_comb begin
      wheelbase_in   = wheelbase_ff;
      speed_limit_in = speed_limit_ff;
      steer_limit_in = steer_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WHEELBASE:   wheelbase_in   = csr_wdata[WB_W-1:0];
            CSR_SPEED_LIMIT: speed_limit_in = csr_wdata[SLIM_W-1:0];
            CSR_STEER_LIMIT: steer_limit_in = csr_wdata[STLIM_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff   <= WHEELBASE_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
         steer_limit_ff <= STEER_LIMIT_RST;
      end else begin
         wheelbase_ff   <= wheelbase_in;
         speed_limit_ff <= speed_limit_in;
         steer_limit_ff <= steer_limit_in;
      end
   end

   // Clamp speed, form the cordic operands and prerotate into the right half plane.
   tac_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_data),
      .wheelbase_mm (wheelbase_ff),
      .speed_limit  (speed_limit_ff),
      .cell_out     (cell_q[0])
   );

   // Chain of cordic cells; cell i shifts by i and adds or subtracts atan(2^-i).
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      tac_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .stage    (ATAN_IDX_W'(i)),
         .cell_in  (cell_q[i]),
         .cell_out (cell_q[i+1])
      );
   end

   // Convert to mrad, clamp, flip for forward motion and present the transfer.
   tac_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cell_in     (cell_q[CORDIC_STAGES]),
      .steer_limit (steer_limit_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

>>> hw/rtl/tac_front.sv
// Speed clamp, operand products and half-turn prerotation ahead of the cordic chain.
`timescale 1ns / 1ps
`default_nettype none
module tac_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire tac_pkg::req_type            req,
   input  wire logic [tac_pkg::WB_W-1:0]    wheelbase_mm,
   input  wire logic [tac_pkg::SLIM_W-1:0]  speed_limit,
   output tac_pkg::cell_type                cell_out
);
   import tac_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SPEED_W-1:0]  s1_speed_ff, s1_speed_in;
   logic [SLIM_W-1:0]          s1_abs_ff, s1_abs_in;
   logic signed [Y_W-1:0]      s1_y_ff, s1_y_in;
   logic                       s1_zero_ff, s1_zero_in;

   logic signed [SPEED_W:0]    v_ext, lim_pos, lim_neg;
   logic signed [SPEED_W:0]    v_cl;
   logic signed [WB_W:0]       wb_s;

   cell_type                   out_ff, out_in;
   logic [XMAG_W-1:0]          x_mag;
   logic signed [Y_W-1:0]      y_rot;
   logic                       x_neg;

   // stage 1: clamp speed, form wheelbase * yaw rate
   always_comb begin
      v_ext   = (SPEED_W+1)'(req.linear_speed);
      lim_pos = $signed({2'b00, speed_limit});
      lim_neg = -lim_pos;
      if (v_ext > lim_pos) begin
         v_cl = lim_pos;
      end else if (v_ext < lim_neg) begin
         v_cl = lim_neg;
      end else begin
         v_cl = v_ext;
      end
      wb_s        = $signed({1'b0, wheelbase_mm});
      s1_valid_in = accept;
      s1_speed_in = v_cl[SPEED_W-1:0];
      s1_abs_in   = v_cl[SPEED_W] ? SLIM_W'(-v_cl) : SLIM_W'(v_cl);
      s1_y_in     = wb_s * req.yaw_rate;
      s1_zero_in  = (req.yaw_rate == '0) || (wheelbase_mm == '0);
   end

   // stage 2: |speed| * 1000, turn by pi when speed is negative, scale up
   always_comb begin
      x_neg        = s1_speed_ff[SPEED_W-1];
      x_mag        = XMAG_W'(s1_abs_ff) * XMAG_W'(MRAD_SCALE);
      y_rot        = x_neg ? -s1_y_ff : s1_y_ff;
      out_in.valid = s1_valid_ff;
      out_in.zero  = s1_zero_ff || (s1_speed_ff == '0);
      out_in.speed = s1_speed_ff;
      out_in.x     = $signed(XY_W'(x_mag)) <<< PRESHIFT;
      out_in.y     = XY_W'(y_rot) <<< PRESHIFT;
      if (!x_neg) begin
         out_in.z = '0;
      end else if (s1_y_ff[Y_W-1]) begin
         out_in.z = -PI_Q30;
      end else begin
         out_in.z = PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_ff.valid <= out_in.valid;
      end
      s1_speed_ff <= s1_speed_in;
      s1_abs_ff   <= s1_abs_in;
      s1_y_ff     <= s1_y_in;
      s1_zero_ff  <= s1_zero_in;
      out_ff.zero  <= out_in.zero;
      out_ff.speed <= out_in.speed;
      out_ff.x     <= out_in.x;
      out_ff.y     <= out_in.y;
      out_ff.z     <= out_in.z;
   end

   assign cell_out = out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/tac_cordic_cell.sv
// One vectoring cordic step: rotate toward y = 0 and pass the token on.
`timescale 1ns / 1ps
`default_nettype none
module tac_cordic_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [tac_pkg::ATAN_IDX_W-1:0]  stage,
   input  wire tac_pkg::cell_type               cell_in,
   output tac_pkg::cell_type                    cell_out
);
   import tac_pkg::*;

   cell_type               out_ff, out_in;
   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  da;

   always_comb begin
      dx     = cell_in.y >>> stage;
      dy     = cell_in.x >>> stage;
      da     = atan_q30(stage);
      out_in = cell_in;
      if (!cell_in.y[XY_W-1]) begin
         out_in.x = cell_in.x + dx;
         out_in.y = cell_in.y - dy;
         out_in.z = cell_in.z + da;
      end else begin
         out_in.x = cell_in.x - dx;
         out_in.y = cell_in.y + dy;
         out_in.z = cell_in.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.zero  <= out_in.zero;
      out_ff.speed <= out_in.speed;
      out_ff.x     <= out_in.x;
      out_ff.y     <= out_in.y;
      out_ff.z     <= out_in.z;
   end

   assign cell_out = out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/tac_back.sv
// Angle to milliradians, steering clamp and direction flip.
`timescale 1ns / 1ps
`default_nettype none
module tac_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tac_pkg::cell_type            cell_in,
   input  wire logic [tac_pkg::STLIM_W-1:0]  steer_limit,
   output logic                              rsp_strobe,
   output tac_pkg::rsp_type                  rsp_data
);
   import tac_pkg::*;

   logic                      a_valid_ff, a_valid_in;
   logic                      a_zero_ff, a_zero_in;
   logic                      a_zneg_ff, a_zneg_in;
   logic signed [SPEED_W-1:0] a_speed_ff, a_speed_in;
   logic [PROD_W-1:0]         a_prod_ff, a_prod_in;
   logic [MAG_W-1:0]          mag;

   logic                      strobe_ff, strobe_in;
   rsp_type                   rsp_ff, rsp_in;
   logic [PROD_W-1:0]         rounded;
   logic [R_W-1:0]            r;
   logic [STLIM_W-1:0]        rc;
   logic                      flip;

   // stage A: |angle| * 1000
   always_comb begin
      mag        = cell_in.z[Z_W-1] ? MAG_W'(-cell_in.z) : MAG_W'(cell_in.z);
      a_valid_in = cell_in.valid;
      a_zero_in  = cell_in.zero;
      a_zneg_in  = cell_in.z[Z_W-1];
      a_speed_in = cell_in.speed;
      a_prod_in  = PROD_W'(mag) * PROD_W'(MRAD_SCALE);
   end

   // stage B: round half away from zero, clamp, flip sign for forward motion, zero steering on zero flag
   always_comb begin
      rounded = a_prod_ff + ROUND_HALF;
      r       = rounded[PROD_W-1:FRAC_W];
      rc      = (r > R_W'(steer_limit)) ? steer_limit : r[STLIM_W-1:0];
      flip    = a_zneg_ff ^ !a_speed_ff[SPEED_W-1];
      strobe_in          = a_valid_ff;
      rsp_in.speed_cmd   = a_speed_ff;
      if (a_zero_ff) begin
         rsp_in.steering_cmd = '0;
      end else if (flip) begin
         rsp_in.steering_cmd = -$signed(STEER_W'(rc));
      end else begin
         rsp_in.steering_cmd = $signed(STEER_W'(rc));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         strobe_ff  <= strobe_in;
      end
      a_zero_ff  <= a_zero_in;
      a_zneg_ff  <= a_zneg_in;
      a_speed_ff <= a_speed_in;
      a_prod_ff  <= a_prod_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire
